[sv/lnfw_pkg.sv]
`default_nettype none

package lnfw_pkg;

    // Display address command bytes
    localparam logic [7:0] ADDR_BASE    = 8'h80;
    localparam logic [7:0] LINE2_OFFSET = 8'h40;
    localparam logic [1:0] FIRST_LINE   = 2'd1;

    // Character codes
    localparam logic [7:0] DIGIT_BASE  = 8'h30;
    localparam logic [7:0] LETTER_BASE = 8'h37;
    localparam logic [3:0] DEC_RADIX   = 4'd10;

    // Radix select codes on the cmd field
    localparam logic RADIX_DEC = 1'b0;
    localparam logic RADIX_HEX = 1'b1;

    // Divide by ten: q = (v * DEC_RECIP) >> RECIP_SHIFT, exact for v below 2**32
    localparam logic [31:0] DEC_RECIP   = 32'hCCCC_CCCD;
    localparam int          RECIP_SHIFT = 35;
    localparam int          HEX_SHIFT   = 4;

    typedef struct packed {
        logic start;
        logic hex;
    } lnfw_div_req_t;

    function automatic logic [7:0] digit_char(input logic [3:0] d);
        logic [7:0] code;
        if (d < DEC_RADIX)
        begin
            code = DIGIT_BASE + {4'd0, d};
        end
        else
        begin
            code = LETTER_BASE + {4'd0, d};
        end
        return code;
    endfunction

endpackage

`default_nettype wire

[sv/lnfw_in_if.sv]
`default_nettype none

interface lnfw_in_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic [1:0]  line;
    logic [5:0]  column;
    logic [15:0] value;
    logic [4:0]  digit_count;

    modport source (
        output valid, cmd, line, column, value, digit_count,
        input  ready
    );

    modport sink (
        input  valid, cmd, line, column, value, digit_count,
        output ready
    );
endinterface

`default_nettype wire

[sv/lnfw_out_if.sv]
`default_nettype none

interface lnfw_out_if;
    logic       valid;
    logic       ready;
    logic       is_data;
    logic [7:0] code_byte;
    logic       last;

    modport source (
        output valid, is_data, code_byte, last,
        input  ready
    );

    modport sink (
        input  valid, is_data, code_byte, last,
        output ready
    );
endinterface

`default_nettype wire

[sv/lcd_number_field_writer.sv]
// Sequence: the address beat is registered from the address state once the
//   output slot is free; each digit step (request, then result from the shared
//   radix unit) runs only while the remaining value is nonzero, then data beats
//   follow one per cycle while the output is not stalled.
// Fields: one at a time, as input is ready only in idle; the digit steps of a
//   field never outnumber its requested digits.
// Reset: asynchronous, clears the sequencer and output valid; no clearing pass.
`default_nettype none

module lcd_number_field_writer #(
    parameter int MAX_DIGITS = 16,
    parameter int VALUE_BITS = 16
) (
    input  wire         clk,
    input  wire         rst_n,
    lnfw_in_if.sink     in_ch,
    lnfw_out_if.source  out_ch
);
    import lnfw_pkg::*;

    localparam int CNT_W = $clog2(MAX_DIGITS + 1);
    localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
    localparam int EXT_W = (VALUE_BITS > 16) ? VALUE_BITS : 16;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADDR,
        ST_DIV,
        ST_DIV_WAIT,
        ST_EMIT
    } state_t;

    state_t                state_reg, state_next;
    logic                  hex_reg, hex_next;
    logic [CNT_W-1:0]      n_reg, n_next;
    logic [CNT_W-1:0]      k_reg, k_next;
    logic [IDX_W-1:0]      e_reg, e_next;
    logic [VALUE_BITS-1:0] v_reg, v_next;
    logic [7:0]            addr_reg, addr_next;
    logic                  ovalid_reg, ovalid_next;
    logic                  odata_reg, odata_next;
    logic [7:0]            obyte_reg, obyte_next;
    logic                  olast_reg, olast_next;

    logic [3:0]            digit_reg [MAX_DIGITS];

    lnfw_div_req_t         div_req;
    logic                  div_done;
    logic [VALUE_BITS-1:0] div_quo;
    logic [3:0]            div_rem;

    logic                  in_beat;
    logic                  slot_free;
    logic [EXT_W-1:0]      value_ext;
    logic [3:0]            emit_digit;

    // Shared radix unit: one quotient/remainder step per request
    lnfw_radix_unit #(
        .VALUE_BITS (VALUE_BITS)
    ) u_radix (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .v     (v_reg),
        .done  (div_done),
        .quo   (div_quo),
        .rem   (div_rem)
    );

    assign in_ch.ready = (state_reg == ST_IDLE);
    assign in_beat     = in_ch.valid && in_ch.ready;

    // Output register can take a new beat when empty or being drained
    assign slot_free = !ovalid_reg || out_ch.ready;

    assign value_ext = EXT_W'(in_ch.value);

    // Digits past the last computed step are leading zeros
    assign emit_digit = (CNT_W'(e_reg) < k_reg) ? digit_reg[e_reg] : 4'd0;

    always_comb
    begin
        state_next  = state_reg;
        hex_next    = hex_reg;
        n_next      = n_reg;
        k_next      = k_reg;
        e_next      = e_reg;
        v_next      = v_reg;
        addr_next   = addr_reg;
        ovalid_next = ovalid_reg;
        odata_next  = odata_reg;
        obyte_next  = obyte_reg;
        olast_next  = olast_reg;
        div_req     = '0;

        if (ovalid_reg && out_ch.ready)
        begin
            ovalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_beat)
                begin
                    hex_next  = (in_ch.cmd == RADIX_HEX);
                    v_next    = value_ext[VALUE_BITS-1:0];
                    k_next    = '0;
                    addr_next = ADDR_BASE
                              + ((in_ch.line == FIRST_LINE) ? 8'd0 : LINE2_OFFSET)
                              + {2'b00, in_ch.column} - 8'd1;
                    if (in_ch.digit_count > 5'(MAX_DIGITS))
                    begin
                        n_next = CNT_W'(MAX_DIGITS);
                    end
                    else
                    begin
                        n_next = CNT_W'(in_ch.digit_count);
                    end
                    state_next = ST_ADDR;
                end
            end

            ST_ADDR:
            begin
                if (slot_free)
                begin
                    ovalid_next = 1'b1;
                    odata_next  = 1'b0;
                    obyte_next  = addr_reg;
                    olast_next  = (n_reg == '0);
                    state_next  = (n_reg == '0) ? ST_IDLE : ST_DIV;
                end
            end

            ST_DIV:
            begin
                // Stop when all digits are computed, or early once the value is exhausted
                if (k_reg == n_reg || v_reg == '0)
                begin
                    e_next     = IDX_W'(n_reg - CNT_W'(1));
                    state_next = ST_EMIT;
                end
                else
                begin
                    div_req.start = 1'b1;
                    div_req.hex   = hex_reg;
                    state_next    = ST_DIV_WAIT;
                end
            end

            ST_DIV_WAIT:
            begin
                if (div_done)
                begin
                    v_next     = div_quo;
                    k_next     = k_reg + CNT_W'(1);
                    state_next = ST_DIV;
                end
            end

            ST_EMIT:
            begin
                if (slot_free)
                begin
                    ovalid_next = 1'b1;
                    odata_next  = 1'b1;
                    obyte_next  = digit_char(emit_digit);
                    olast_next  = (e_reg == '0);
                    if (e_reg == '0)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        e_next = e_reg - IDX_W'(1);
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            ovalid_reg <= 1'b0;
            hex_reg    <= 1'b0;
            n_reg      <= '0;
            k_reg      <= '0;
            e_reg      <= '0;
            odata_reg  <= 1'b0;
            olast_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
            hex_reg    <= hex_next;
            n_reg      <= n_next;
            k_reg      <= k_next;
            e_reg      <= e_next;
            odata_reg  <= odata_next;
            olast_reg  <= olast_next;
        end
    end

    // Payload: value under conversion, address byte, output byte, digit buffer
    always_ff @(posedge clk)
    begin
        v_reg     <= v_next;
        addr_reg  <= addr_next;
        obyte_reg <= obyte_next;
        if (state_reg == ST_DIV_WAIT && div_done)
        begin
            digit_reg[k_reg[IDX_W-1:0]] <= div_rem;
        end
    end

    assign out_ch.valid     = ovalid_reg;
    assign out_ch.is_data   = odata_reg;
    assign out_ch.code_byte = obyte_reg;
    assign out_ch.last      = olast_reg;

    // Never hold more computed digits than requested
    assert property (@(posedge clk) disable iff (!rst_n)
        k_reg <= n_reg)
        else $error("digit step count exceeds field width");

    // Radix results arrive only while the sequencer waits for them
    assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DIV_WAIT))
        else $error("radix result outside wait state");

    // A pending beat that is not the last one keeps the input closed
    assert property (@(posedge clk) disable iff (!rst_n)
        (ovalid_reg && !olast_reg) |-> !in_ch.ready)
        else $error("input open with field still in flight");

    // An accepted field is followed by a busy cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_beat |=> !in_ch.ready)
        else $error("input taken twice in a row");

endmodule

`default_nettype wire

[sv/lnfw_radix_unit.sv]
`default_nettype none

// One radix step: quotient and remainder of v by ten or sixteen.
// Result is valid the cycle after start (product registered in between).
module lnfw_radix_unit #(
    parameter int VALUE_BITS = 16
) (
    input  wire                         clk,
    input  wire                         rst_n,
    input  lnfw_pkg::lnfw_div_req_t     req,
    input  wire [VALUE_BITS-1:0]        v,
    output logic                        done,
    output logic [VALUE_BITS-1:0]       quo,
    output logic [3:0]                  rem
);
    import lnfw_pkg::*;

    localparam int PW = VALUE_BITS + 32;

    logic [PW-1:0]         prod_reg;
    logic [PW-1:0]         prod_next;
    logic [VALUE_BITS-1:0] src_reg;
    logic                  hex_reg;
    logic                  done_reg;
    logic [VALUE_BITS-1:0] q_dec;
    logic [VALUE_BITS-1:0] diff;

    assign prod_next = PW'(v) * PW'(DEC_RECIP);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= req.start;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            prod_reg <= prod_next;
            src_reg  <= v;
            hex_reg  <= req.hex;
        end
    end

    always_comb
    begin
        q_dec = VALUE_BITS'(prod_reg >> RECIP_SHIFT);
        // v - 10*q, ten as eight plus two
        diff  = src_reg - (q_dec << 3) - (q_dec << 1);
        if (hex_reg)
        begin
            quo = src_reg >> HEX_SHIFT;
            rem = src_reg[3:0];
        end
        else
        begin
            quo = q_dec;
            rem = diff[3:0];
        end
    end

    assign done = done_reg;

endmodule

`default_nettype wire

[tb/sv/lnfw_field_checker.sv]
`timescale 1ns / 1ps

module lnfw_field_checker #(
    parameter int MAX_DIGITS = 16,
    parameter int VALUE_BITS = 16
) (
    input  wire  clk,
    input  wire  rst_n,
    lnfw_in_if   in_mon,
    lnfw_out_if  out_mon,
    output int   errors,
    output int   pending
);
    import lnfw_pkg::*;

    localparam int HEX_RADIX = 16;

    typedef struct packed {
        logic       is_data;
        logic [7:0] code_byte;
        logic       last;
    } lcd_write_t;

    lcd_write_t expected_writes[$];
    int         mismatch_count;

    // Build the address command and the digit writes for one field request.
    function automatic void predict_field_writes(
        input logic        cmd,
        input logic [1:0]  line,
        input logic [5:0]  column,
        input logic [15:0] value,
        input logic [4:0]  digit_count
    );
        logic [7:0]  addr;
        logic [7:0]  line_offset;
        logic [63:0] rest;
        logic [3:0]  digits [0:MAX_DIGITS-1];
        int          radix;
        int          n;
        lcd_write_t  wr;
        line_offset = (line == FIRST_LINE) ? 8'h00 : LINE2_OFFSET;
        addr = ADDR_BASE + line_offset + {2'b00, column} - 8'd1;
        n = (int'(digit_count) > MAX_DIGITS) ? MAX_DIGITS : int'(digit_count);
        radix = (cmd == RADIX_HEX) ? HEX_RADIX : int'(DEC_RADIX);
        wr.is_data = 1'b0;
        wr.code_byte = addr;
        wr.last = (n == 0);
        expected_writes.push_back(wr);
        // Peel digits least significant first; high positions fall to zero.
        rest = 64'(value) & ((64'd1 << VALUE_BITS) - 64'd1);
        for (int i = 0; i < n; i++)
        begin
            digits[i] = 4'(rest % radix);
            rest = rest / radix;
        end
        for (int i = n - 1; i >= 0; i--)
        begin
            wr.is_data = 1'b1;
            if (digits[i] < DEC_RADIX)
            begin
                wr.code_byte = DIGIT_BASE + {4'd0, digits[i]};
            end
            else
            begin
                wr.code_byte = LETTER_BASE + {4'd0, digits[i]};
            end
            wr.last = (i == 0);
            expected_writes.push_back(wr);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        lcd_write_t want;
        if (!rst_n)
        begin
            expected_writes.delete();
            mismatch_count = 0;
            errors  <= 0;
            pending <= 0;
        end
        else
        begin
            // Retire the output beat first; it always belongs to an older field.
            if (out_mon.valid && out_mon.ready)
            begin
                if (expected_writes.size() == 0)
                begin
                    $display("%0t: unexpected write is_data=%0b code_byte=%02h last=%0b",
                             $time, out_mon.is_data, out_mon.code_byte, out_mon.last);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_writes.pop_front();
                    if (out_mon.is_data !== want.is_data)
                    begin
                        $display("%0t: is_data mismatch: expected %0b, actual %0b",
                                 $time, want.is_data, out_mon.is_data);
                        mismatch_count++;
                    end
                    if (out_mon.code_byte !== want.code_byte)
                    begin
                        $display("%0t: code_byte mismatch: expected %02h, actual %02h",
                                 $time, want.code_byte, out_mon.code_byte);
                        mismatch_count++;
                    end
                    if (out_mon.last !== want.last)
                    begin
                        $display("%0t: last mismatch: expected %0b, actual %0b",
                                 $time, want.last, out_mon.last);
                        mismatch_count++;
                    end
                end
            end
            if (in_mon.valid && in_mon.ready)
            begin
                predict_field_writes(in_mon.cmd, in_mon.line, in_mon.column,
                                     in_mon.value, in_mon.digit_count);
            end
            errors  <= mismatch_count;
            pending <= expected_writes.size();
        end
    end

endmodule

[tb/sv/tb_lcd_number_field_writer.sv]
`timescale 1ns / 1ps

module tb_lcd_number_field_writer;
    import lnfw_pkg::*;

    localparam int MAX_DIGITS     = 16;
    localparam int VALUE_BITS     = 16;
    localparam int RANDOM_FIELDS  = 210;
    // Worst field: sixteen digit steps and sixteen data beats; leave margin for the tail.
    localparam int DRAIN_CYCLES   = 64;
    // Longest quiet stretch is the receiver hold-off plus one slow field.
    localparam int HOLD_OFF       = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_AFTER     = 80;

    typedef struct packed {
        logic        cmd;
        logic [1:0]  line;
        logic [5:0]  column;
        logic [15:0] value;
        logic [4:0]  digit_count;
    } field_req_t;

    logic clk;
    logic rst_n;
    int   errors;
    int   pending;
    int   fields_sent;
    int   quiet_cycles;

    lnfw_in_if  in_ch();
    lnfw_out_if out_ch();

    lcd_number_field_writer #(
        .MAX_DIGITS(MAX_DIGITS),
        .VALUE_BITS(VALUE_BITS)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .in_ch (in_ch),
        .out_ch(out_ch)
    );

    lnfw_field_checker #(
        .MAX_DIGITS(MAX_DIGITS),
        .VALUE_BITS(VALUE_BITS)
    ) field_checker (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_mon (in_ch),
        .out_mon(out_ch),
        .errors (errors),
        .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // Offer one field and hold it until the block takes the beat. Valid stays
    // high on return so the next field can follow without a bubble.
    task automatic send_field(input field_req_t req);
        in_ch.valid       <= 1'b1;
        in_ch.cmd         <= req.cmd;
        in_ch.line        <= req.line;
        in_ch.column      <= req.column;
        in_ch.value       <= req.value;
        in_ch.digit_count <= req.digit_count;
        do
        begin
            @(posedge clk);
        end
        while (!in_ch.ready);
        fields_sent++;
    endtask

    // Drop valid for a gap between bursts.
    task automatic idle_input(input int cycles);
        if (cycles > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    function automatic field_req_t make_req(
        input logic        cmd,
        input logic [1:0]  line,
        input logic [5:0]  column,
        input logic [15:0] value,
        input logic [4:0]  digit_count
    );
        field_req_t req;
        req.cmd         = cmd;
        req.line        = line;
        req.column      = column;
        req.value       = value;
        req.digit_count = digit_count;
        return req;
    endfunction

    // Mix value shapes: full random, small numbers, near-max, single bits.
    function automatic logic [15:0] pick_value();
        logic [15:0] v;
        case ($urandom_range(0, 3))
            0: v = 16'($urandom);
            1: v = 16'($urandom_range(0, 99));
            2: v = 16'hFFFF - 16'($urandom_range(0, 15));
            default: v = 16'(1) << $urandom_range(0, 15);
        endcase
        return v;
    endfunction

    // Most fields are on-screen requests of a few digits; the rest are noise
    // across every bit of line, column and digit_count.
    function automatic field_req_t random_req();
        field_req_t req;
        req.cmd   = 1'($urandom_range(0, 1));
        req.value = pick_value();
        if ($urandom_range(0, 99) < 85)
        begin
            req.line   = 2'($urandom_range(1, 2));
            req.column = 6'($urandom_range(1, 40));
            if ($urandom_range(0, 9) < 7)
            begin
                req.digit_count = 5'($urandom_range(1, 6));
            end
            else
            begin
                req.digit_count = 5'($urandom_range(7, MAX_DIGITS));
            end
        end
        else
        begin
            req.line        = 2'($urandom_range(0, 3));
            req.column      = 6'($urandom_range(0, 63));
            req.digit_count = 5'($urandom_range(0, 31));
        end
        return req;
    endfunction

    // Receiver: ready cycles through a set of patterns. Once
    // enough fields have been sent, hold ready low for a long stretch so the
    // block backs up and stalls its input.
    initial
    begin
        int cyc;
        int mode;
        bit held;
        cyc  = 0;
        held = 1'b0;
        out_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (!held && fields_sent >= HOLD_AFTER)
            begin
                out_ch.ready <= 1'b0;
                repeat (HOLD_OFF) @(posedge clk);
                held = 1'b1;
            end
            else
            begin
                mode = (cyc / 64) % 4;
                case (mode)
                    0: out_ch.ready <= 1'b1;
                    1: out_ch.ready <= ($urandom_range(0, 3) != 0);
                    2: out_ch.ready <= ((cyc % 5) >= 2);
                    default: out_ch.ready <= 1'($urandom_range(0, 1));
                endcase
                cyc++;
                @(posedge clk);
            end
        end
    end

    // Watchdog: end the run if no beat moves on either channel for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("** lcd_number_field_writer: FAILED **");
                $finish;
            end
        end
    end

    // Stimulus and verdict.
    initial
    begin
        int burst_left;
        int gap;
        fields_sent  = 0;
        quiet_cycles = 0;
        rst_n <= 1'b0;
        in_ch.valid       <= 1'b0;
        in_ch.cmd         <= RADIX_DEC;
        in_ch.line        <= '0;
        in_ch.column      <= '0;
        in_ch.value       <= '0;
        in_ch.digit_count <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: field extremes, both radixes, every line code, column
        // wrap, saturated and empty digit counts, digits past the value width.
        send_field(make_req(RADIX_DEC, 2'd1, 6'd1,  16'd0,     5'd5));
        send_field(make_req(RADIX_HEX, 2'd1, 6'd1,  16'hFFFF,  5'd4));
        send_field(make_req(RADIX_DEC, 2'd2, 6'd40, 16'd65535, 5'd5));
        send_field(make_req(RADIX_HEX, 2'd2, 6'd16, 16'hABCD,  5'd4));
        send_field(make_req(RADIX_DEC, 2'd1, 6'd0,  16'd12345, 5'd16));
        send_field(make_req(RADIX_HEX, 2'd0, 6'd0,  16'hFEDC,  5'd16));
        send_field(make_req(RADIX_DEC, 2'd3, 6'd63, 16'd9,     5'd17));
        send_field(make_req(RADIX_HEX, 2'd1, 6'd63, 16'h5A5A,  5'd31));
        send_field(make_req(RADIX_DEC, 2'd2, 6'd20, 16'd777,   5'd0));
        send_field(make_req(RADIX_HEX, 2'd1, 6'd41, 16'hFFFF,  5'd0));
        idle_input(3);
        send_field(make_req(RADIX_DEC, 2'd1, 6'd10, 16'd65535, 5'd1));
        send_field(make_req(RADIX_HEX, 2'd2, 6'd8,  16'h00F0,  5'd2));
        send_field(make_req(RADIX_DEC, 2'd0, 6'd42, 16'd1000,  5'd6));
        send_field(make_req(RADIX_HEX, 2'd3, 6'd32, 16'h8000,  5'd8));
        send_field(make_req(RADIX_DEC, 2'd1, 6'd5,  16'd10,    5'd2));
        send_field(make_req(RADIX_HEX, 2'd2, 6'd33, 16'h0009,  5'd1));
        send_field(make_req(RADIX_DEC, 2'd2, 6'd2,  16'h5555,  5'd10));
        send_field(make_req(RADIX_HEX, 2'd1, 6'd21, 16'hAAAA,  5'd5));

        // Random: bursts of fields with random gaps; one stretch runs with
        // no input gaps at all.
        burst_left = 0;
        for (int n = 0; n < RANDOM_FIELDS; n++)
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 12);
                if (n >= 100 && n < 140)
                begin
                    gap = 0;
                end
                else if ($urandom_range(0, 9) < 3)
                begin
                    gap = 0;
                end
                else
                begin
                    gap = $urandom_range(1, 8);
                end
                idle_input(gap);
            end
            send_field(random_req());
            burst_left--;
        end
        in_ch.valid <= 1'b0;

        // Wait for the next edge so the last beat's expectations are counted, then
        // drain and let the tail settle.
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0 && pending == 0)
        begin
            $display("** lcd_number_field_writer: PASSED **");
        end
        else
        begin
            $display("** lcd_number_field_writer: FAILED **");
        end
        $finish;
    end

endmodule
